>>> design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is suspended while reset is asserted.
`define IMH_CHECK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check that also runs during reset.
`define IMH_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/imh_pkg.sv
package imh_pkg;

  localparam int KEY_W       = 10;
  localparam int VAL_IN_W    = 32;
  localparam int CNT_W       = 11;
  localparam int MAX_KEYS    = 1024;
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_DUP    = 2'd1,
    STS_ABSENT = 2'd2,
    STS_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_DEL_LAST,
    S_DEL_PAR,
    S_UP,
    S_DN_L,
    S_DN_R,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]    entry_count;
    logic [VAL_IN_W-1:0] top_value;
    logic [KEY_W-1:0]    top_key;
    logic                top_valid;
    status_t             status;
  } result_t;

endpackage

>>> design/imh_slot_mem.sv
module imh_slot_mem #(
  parameter int DEPTH = 1025,
  parameter int AW    = 11,
  parameter int DW    = 42
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/imh_pos_mem.sv
module imh_pos_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic          ready
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] clr_idx_r;
  logic [AW-1:0] clr_idx_nxt;
  logic          clr_busy_r;
  logic          clr_busy_nxt;

  // clearing pass: one entry per cycle after reset
  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_idx_r  <= clr_idx_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

endmodule

>>> design/indexed_min_heap.sv
// Indexed binary min-heap of distinct keys with a value per key. Each input transfer
// (tuser = 0 insert, 1 delete) yields exactly one result transfer with the status, the
// current minimum entry and the entry count. One item is processed at a time through a
// heap-slot RAM, a position-table RAM and a small key-compare datapath: the item is
// accepted and looked up, a delete then fetches the last entry, a sift moves one level
// per step up, or down with a left-child and, where there is one, a right-child read per
// level, then the entry is placed and the result is written. An item stays in its result
// state while the previous result still waits for out_tready. After reset the position
// table is cleared one entry per cycle, min(NUM_KEYS, 1024) entries, and in_tready stays
// low until done. A finished result is held in an output register, so the next item may
// be accepted while it waits.
module indexed_min_heap #(
  parameter int NUM_KEYS    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [imh_pkg::IN_TDATA_W-1:0]      in_tdata,   // item_key, item_value, zero pad
  input  logic [imh_pkg::IN_TUSER_W-1:0]      in_tuser,   // command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [imh_pkg::OUT_TDATA_W-1:0]     out_tdata   // status, top_valid, top_key,
                                                          // top_value, entry_count
);

  localparam int KT  = (NUM_KEYS < imh_pkg::MAX_KEYS) ? NUM_KEYS : imh_pkg::MAX_KEYS;
  localparam int KW  = $clog2(KT);
  localparam int SLW = $clog2(KT + 1);
  localparam int SW  = (VALUE_WIDTH < imh_pkg::VAL_IN_W) ? VALUE_WIDTH : imh_pkg::VAL_IN_W;
  localparam int EW  = imh_pkg::KEY_W + SW;

  imh_pkg::state_t  state_r, state_nxt;
  imh_pkg::cmd_t    cmd_r, cmd_nxt;
  imh_pkg::status_t status_r, status_nxt;
  imh_pkg::result_t out_data_r, out_data_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [imh_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [SW-1:0]             val_r, val_nxt;
  logic [SLW-1:0]            fill_r, fill_nxt;
  logic [SLW-1:0]            s_r, s_nxt;
  logic [SLW-1:0]            c_r, c_nxt;
  logic [imh_pkg::KEY_W-1:0] mk_r, mk_nxt;
  logic [SW-1:0]             mv_r, mv_nxt;
  logic [imh_pkg::KEY_W-1:0] ck_r, ck_nxt;
  logic [SW-1:0]             cv_r, cv_nxt;
  logic [imh_pkg::KEY_W-1:0] top_key_r, top_key_nxt;
  logic [SW-1:0]             top_val_r, top_val_nxt;

  logic [imh_pkg::KEY_W-1:0]    in_key;
  logic [imh_pkg::VAL_IN_W-1:0] in_val;
  logic                         in_fire;
  logic                         out_free;

  logic [SLW-1:0] heap_raddr, heap_waddr;
  logic [EW-1:0]  heap_rdata, heap_wdata;
  logic           heap_we;
  logic [KW-1:0]  pos_raddr, pos_waddr;
  logic [SLW-1:0] pos_rdata, pos_wdata;
  logic           pos_we;
  logic           pos_ready;

  logic [imh_pkg::KEY_W-1:0] rd_key, ch_key;
  logic [SW-1:0]             rd_val, ch_val;
  logic [SLW-1:0]            par_s, ins_s, c_inc, c_sel, dn_from;
  logic [SLW:0]              dn_c;
  logic                      up_move, dn_move, dn_go, has_right, r_better;
  logic                      key_oob, is_full, ins_ok, del_ok;

  assign in_key   = in_tdata[imh_pkg::KEY_W-1:0];
  assign in_val   = in_tdata[imh_pkg::KEY_W +: imh_pkg::VAL_IN_W];
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == imh_pkg::S_IDLE) && pos_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  imh_slot_mem #(
    .DEPTH (KT + 1),
    .AW    (SLW),
    .DW    (EW)
  ) u_slot_mem (
    .clk     (clk),
    .rd_addr (heap_raddr),
    .rd_data (heap_rdata),
    .wr_en   (heap_we),
    .wr_addr (heap_waddr),
    .wr_data (heap_wdata)
  );

  imh_pos_mem #(
    .DEPTH (KT),
    .AW    (KW),
    .DW    (SLW)
  ) u_pos_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (pos_raddr),
    .rd_data (pos_rdata),
    .wr_en   (pos_we),
    .wr_addr (pos_waddr),
    .wr_data (pos_wdata),
    .ready   (pos_ready)
  );

  // shared compare datapath
  assign rd_key    = heap_rdata[EW-1 -: imh_pkg::KEY_W];
  assign rd_val    = heap_rdata[SW-1:0];
  assign par_s     = s_r >> 1;
  assign ins_s     = fill_r + 1'b1;
  assign c_inc     = c_r + 1'b1;
  assign up_move   = rd_key > mk_r;
  assign has_right = c_r < fill_r;
  assign r_better  = rd_key < ck_r;

  always_comb begin
    ch_key = rd_key;
    ch_val = rd_val;
    c_sel  = c_r;
    if (state_r == imh_pkg::S_DN_R) begin
      if (r_better) begin
        c_sel = c_inc;
      end else begin
        ch_key = ck_r;
        ch_val = cv_r;
      end
    end
  end

  assign dn_move = ch_key < mk_r;
  assign dn_from = (state_r == imh_pkg::S_DN_L || state_r == imh_pkg::S_DN_R) ? c_sel : s_r;
  assign dn_c    = {dn_from, 1'b0};
  assign dn_go   = dn_c <= {1'b0, fill_r};

  assign key_oob = 32'(key_r) >= 32'(NUM_KEYS);
  assign is_full = 32'(fill_r) >= 32'(NUM_KEYS);
  assign ins_ok  = !key_oob && !is_full && (pos_rdata == '0);
  assign del_ok  = !key_oob && (pos_rdata != '0) && (pos_rdata <= fill_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imh_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = imh_pkg::S_LOOKUP;
        end
      end
      imh_pkg::S_LOOKUP: begin
        if (cmd_r == imh_pkg::CMD_INSERT) begin
          if (!ins_ok) begin
            state_nxt = imh_pkg::S_DONE;
          end else if (ins_s == SLW'(1)) begin
            state_nxt = imh_pkg::S_PLACE;
          end else begin
            state_nxt = imh_pkg::S_UP;
          end
        end else begin
          state_nxt = del_ok ? imh_pkg::S_DEL_LAST : imh_pkg::S_DONE;
        end
      end
      imh_pkg::S_DEL_LAST: begin
        if (s_r == c_r) begin
          state_nxt = imh_pkg::S_DONE;
        end else if (s_r == SLW'(1)) begin
          state_nxt = dn_go ? imh_pkg::S_DN_L : imh_pkg::S_PLACE;
        end else begin
          state_nxt = imh_pkg::S_DEL_PAR;
        end
      end
      imh_pkg::S_DEL_PAR, imh_pkg::S_UP: begin
        if (up_move) begin
          state_nxt = (par_s > SLW'(1)) ? imh_pkg::S_UP : imh_pkg::S_PLACE;
        end else if (state_r == imh_pkg::S_DEL_PAR && dn_go) begin
          state_nxt = imh_pkg::S_DN_L;
        end else begin
          state_nxt = imh_pkg::S_PLACE;
        end
      end
      imh_pkg::S_DN_L, imh_pkg::S_DN_R: begin
        if (state_r == imh_pkg::S_DN_L && has_right) begin
          state_nxt = imh_pkg::S_DN_R;
        end else if (dn_move && dn_go) begin
          state_nxt = imh_pkg::S_DN_L;
        end else begin
          state_nxt = imh_pkg::S_PLACE;
        end
      end
      imh_pkg::S_PLACE: begin
        state_nxt = imh_pkg::S_DONE;
      end
      imh_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = imh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = imh_pkg::S_IDLE;
      end
    endcase
  end

  // memory control
  always_comb begin
    heap_raddr = s_r;
    heap_we    = 1'b0;
    heap_waddr = s_r;
    heap_wdata = {mk_r, mv_r};
    pos_raddr  = in_key[KW-1:0];
    pos_we     = 1'b0;
    pos_waddr  = mk_r[KW-1:0];
    pos_wdata  = s_r;
    unique case (state_r)
      imh_pkg::S_LOOKUP: begin
        if (cmd_r == imh_pkg::CMD_INSERT) begin
          heap_raddr = ins_s >> 1;
        end else begin
          heap_raddr = fill_r;
          if (del_ok) begin
            pos_we    = 1'b1;
            pos_waddr = key_r[KW-1:0];
            pos_wdata = '0;
          end
        end
      end
      imh_pkg::S_DEL_LAST: begin
        heap_raddr = (s_r == SLW'(1)) ? dn_c[SLW-1:0] : par_s;
      end
      imh_pkg::S_DEL_PAR, imh_pkg::S_UP: begin
        if (up_move) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = rd_key[KW-1:0];
          heap_raddr = par_s >> 1;
        end else begin
          heap_raddr = dn_c[SLW-1:0];
        end
      end
      imh_pkg::S_DN_L, imh_pkg::S_DN_R: begin
        if (state_r == imh_pkg::S_DN_L && has_right) begin
          heap_raddr = c_inc;
        end else if (dn_move) begin
          heap_we    = 1'b1;
          heap_wdata = {ch_key, ch_val};
          pos_we     = 1'b1;
          pos_waddr  = ch_key[KW-1:0];
          heap_raddr = dn_c[SLW-1:0];
        end
      end
      imh_pkg::S_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      imh_pkg::S_IDLE, imh_pkg::S_DONE: begin
        heap_raddr = s_r;
      end
      default: begin
        heap_raddr = s_r;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    fill_nxt      = fill_r;
    s_nxt         = s_r;
    c_nxt         = c_r;
    mk_nxt        = mk_r;
    mv_nxt        = mv_r;
    ck_nxt        = ck_r;
    cv_nxt        = cv_r;
    top_key_nxt   = top_key_r;
    top_val_nxt   = top_val_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      imh_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = imh_pkg::cmd_t'(in_tuser[0]);
          key_nxt = in_key;
          val_nxt = SW'(in_val);
        end
      end
      imh_pkg::S_LOOKUP: begin
        status_nxt = imh_pkg::STS_OK;
        if (cmd_r == imh_pkg::CMD_INSERT) begin
          if (key_oob || is_full) begin
            status_nxt = imh_pkg::STS_FULL;
          end else if (pos_rdata != '0) begin
            status_nxt = imh_pkg::STS_DUP;
          end else begin
            fill_nxt = ins_s;
            s_nxt    = ins_s;
            mk_nxt   = key_r;
            mv_nxt   = val_r;
          end
        end else begin
          if (!del_ok) begin
            status_nxt = imh_pkg::STS_ABSENT;
          end else begin
            s_nxt    = pos_rdata;
            c_nxt    = fill_r;
            fill_nxt = fill_r - 1'b1;
          end
        end
      end
      imh_pkg::S_DEL_LAST: begin
        mk_nxt = rd_key;
        mv_nxt = rd_val;
        c_nxt  = dn_c[SLW-1:0];
      end
      imh_pkg::S_DEL_PAR, imh_pkg::S_UP: begin
        if (up_move) begin
          s_nxt = par_s;
        end else begin
          c_nxt = dn_c[SLW-1:0];
        end
      end
      imh_pkg::S_DN_L, imh_pkg::S_DN_R: begin
        if (state_r == imh_pkg::S_DN_L && has_right) begin
          ck_nxt = rd_key;
          cv_nxt = rd_val;
        end else if (dn_move) begin
          s_nxt = c_sel;
          c_nxt = dn_c[SLW-1:0];
        end
      end
      imh_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.top_valid   = fill_r != '0;
          out_data_nxt.top_key     = (fill_r != '0) ? top_key_r : '0;
          out_data_nxt.top_value   = (fill_r != '0) ? imh_pkg::VAL_IN_W'(top_val_r) : '0;
          out_data_nxt.entry_count = imh_pkg::CNT_W'(fill_r);
        end
      end
      imh_pkg::S_PLACE: begin
        s_nxt = s_r;
      end
      default: begin
        s_nxt = s_r;
      end
    endcase

    // root shadow
    if (heap_we && heap_waddr == SLW'(1)) begin
      top_key_nxt = heap_wdata[EW-1 -: imh_pkg::KEY_W];
      top_val_nxt = heap_wdata[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imh_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    s_r        <= s_nxt;
    c_r        <= c_nxt;
    mk_r       <= mk_nxt;
    mv_r       <= mv_nxt;
    ck_r       <= ck_nxt;
    cv_r       <= cv_nxt;
    top_key_r  <= top_key_nxt;
    top_val_r  <= top_val_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> design/imh_checker.sv
`include "assert_macros.svh"

module imh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [imh_pkg::OUT_TDATA_W-1:0] out_tdata
);

  imh_pkg::result_t res;

  assign res = out_tdata;

  `IMH_CHECK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed while stalled")
  `IMH_CHECK_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "result valid right after reset")
  `IMH_CHECK(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second item taken while busy")
  `IMH_CHECK(a_valid_vs_count, clk, rst_n, out_tvalid |-> (res.top_valid == (res.entry_count != '0)), "top_valid disagrees with count")
  `IMH_CHECK(a_empty_zero, clk, rst_n, out_tvalid && !res.top_valid |-> (res.top_key == '0) && (res.top_value == '0), "empty heap shows a top entry")

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
